FILE: sv/qte_pkg.sv
package qte_pkg;

    // Field widths.
    localparam int QW = 16;          // quaternion component, Q14
    localparam int PRW = 2 * QW;     // product of two components, Q28
    localparam int PW = PRW + 2;     // sums of products, some doubled
    localparam int SW = 30;          // clamped asin argument, +-2^28
    localparam int RW = 29;          // square root, up to 2^28
    localparam int SQ_STAGES = RW;   // one result bit per stage
    localparam int RMW = 59;         // remainder and trial width in the root unit
    localparam int CW = 36;          // CORDIC x/y datapath
    localparam int ZW = 26;          // angle accumulator, 1/65536 degree
    localparam int TW = 22;          // arctangent table entry
    localparam int AXW = 16;         // atan2 output width
    localparam int AYW = 15;         // asin output width

    localparam int QTE_CORDIC_STAGES = 16;
    localparam int ATAN_TABLE_LEN = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam int DEG_UNIT = 65536;
    localparam int ATAN_LIMIT = 23040;
    localparam int ASIN_LIMIT = 11520;
    localparam longint S_LIMIT = 64'sd268435456; // 1.0 in Q28

    typedef struct packed {
        logic signed [PW-1:0] a1y;
        logic signed [PW-1:0] a1x;
        logic signed [PW-1:0] sr;
        logic signed [PW-1:0] a3y;
        logic signed [PW-1:0] a3x;
    } qte_item_t;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic [TW-1:0] atan_entry(input int idx);
        logic [TW-1:0] v;
        v = '0;
        case (idx)
            0:  v = TW'(2949120);
            1:  v = TW'(1740967);
            2:  v = TW'(919879);
            3:  v = TW'(466945);
            4:  v = TW'(234379);
            5:  v = TW'(117304);
            6:  v = TW'(58666);
            7:  v = TW'(29335);
            8:  v = TW'(14668);
            9:  v = TW'(7334);
            10: v = TW'(3667);
            11: v = TW'(1833);
            12: v = TW'(917);
            13: v = TW'(458);
            14: v = TW'(229);
            15: v = TW'(115);
            16: v = TW'(57);
            17: v = TW'(29);
            18: v = TW'(14);
            19: v = TW'(7);
            20: v = TW'(4);
            21: v = TW'(2);
            22: v = TW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/qte_front.sv
module qte_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         quat_valid,
    output logic                         quat_stall,
    input  logic signed [qte_pkg::QW-1:0] quat_w,
    input  logic signed [qte_pkg::QW-1:0] quat_x,
    input  logic signed [qte_pkg::QW-1:0] quat_y,
    input  logic signed [qte_pkg::QW-1:0] quat_z,
    input  logic                         queue_full,
    output logic                         push,
    output qte_pkg::qte_item_t           push_item
);
    import qte_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg;
    logic signed [QW-1:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [PRW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PRW-1:0] yz_reg, wx_reg, wy_reg, xz_reg, xy_reg, wz_reg;
    qte_item_t item_reg;

    assign adv = !v3_reg || !queue_full;
    assign quat_stall = !adv;
    assign push = v3_reg && !queue_full;
    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= quat_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg <= quat_w;
            x_reg <= quat_x;
            y_reg <= quat_y;
            z_reg <= quat_z;
            ww_reg <= w_reg * w_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            yz_reg <= y_reg * z_reg;
            wx_reg <= w_reg * x_reg;
            wy_reg <= w_reg * y_reg;
            xz_reg <= x_reg * z_reg;
            xy_reg <= x_reg * y_reg;
            wz_reg <= w_reg * z_reg;
            item_reg.a1y <= (PW'(yz_reg) + PW'(wx_reg)) <<< 1;
            item_reg.a1x <= PW'(ww_reg) - PW'(xx_reg) - PW'(yy_reg) + PW'(zz_reg);
            item_reg.sr  <= (PW'(wy_reg) - PW'(xz_reg)) <<< 1;
            item_reg.a3y <= (PW'(xy_reg) + PW'(wz_reg)) <<< 1;
            item_reg.a3x <= PW'(ww_reg) + PW'(xx_reg) - PW'(yy_reg) - PW'(zz_reg);
        end
    end

endmodule

FILE: sv/qte_queue.sv
module qte_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  qte_pkg::qte_item_t push_item,
    input  logic               pop,
    output qte_pkg::qte_item_t head_item,
    output logic               not_empty,
    output logic               full
);
    import qte_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    qte_item_t mem_reg [0:QUEUE_DEPTH-1];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0] cnt_reg;

    assign not_empty = cnt_reg != '0;
    assign full = cnt_reg == (AW+1)'(QUEUE_DEPTH);
    assign head_item = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

FILE: sv/qte_isqrt.sv
module qte_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [qte_pkg::SW-1:0] s,
    output logic        [qte_pkg::RW-1:0] root
);
    import qte_pkg::*;

    localparam logic [RMW-1:0] ONE = RMW'(1) << 56;

    logic signed [2*SW-1:0] sq;
    logic [RMW-1:0] rem_reg [0:SQ_STAGES];
    logic [RW-1:0] root_reg [0:SQ_STAGES];

    assign sq = s * s;
    assign root = root_reg[SQ_STAGES];

    // 1 - s^2, then one root bit per stage, most significant first
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ONE - sq[RMW-1:0];
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_stage
        localparam int B = SQ_STAGES - 1 - k;
        logic [RMW-1:0] trial;
        assign trial = ((RMW'(root_reg[k])) << (B + 1)) + (RMW'(1) << (2 * B));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[k] >= trial)
                begin
                    rem_reg[k+1] <= rem_reg[k] - trial;
                    root_reg[k+1] <= root_reg[k] | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k];
                end
            end
        end
    end

endmodule

FILE: sv/qte_cordic.sv
module qte_cordic #(
    parameter int CORDIC_STAGES = qte_pkg::QTE_CORDIC_STAGES
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [qte_pkg::PW-1:0] vy,
    input  logic signed [qte_pkg::PW-1:0] vx,
    output logic signed [qte_pkg::ZW-1:0] angle
);
    import qte_pkg::*;

    localparam logic signed [ZW-1:0] Z90 = ZW'(90 * DEG_UNIT);

    logic signed [CW-1:0] ex, ey;
    logic signed [CW-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STAGES];
    logic zero_reg [0:CORDIC_STAGES];

    assign ex = CW'(vx);
    assign ey = CW'(vy);
    assign angle = zero_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];

    // left half plane: turn by 90 degrees first
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (vx == '0) && (vy == '0);
            if (vx < 0)
            begin
                if (vy >= 0)
                begin
                    x_reg[0] <= ey;
                    y_reg[0] <= -ex;
                    z_reg[0] <= Z90;
                end
                else
                begin
                    x_reg[0] <= -ey;
                    y_reg[0] <= ex;
                    z_reg[0] <= -Z90;
                end
            end
            else
            begin
                x_reg[0] <= ex;
                y_reg[0] <= ey;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [ZW-1:0] step;
        assign step = $signed(ZW'(atan_entry(i)));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + step;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - step;
                end
            end
        end
    end

endmodule

FILE: sv/qte_back.sv
module qte_back #(
    parameter int CORDIC_STAGES = qte_pkg::QTE_CORDIC_STAGES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  qte_pkg::qte_item_t             head_item,
    input  logic                           not_empty,
    output logic                           pop,
    output logic                           angle_valid,
    input  logic                           angle_stall,
    output logic signed [qte_pkg::AXW-1:0] angle_about_x,
    output logic signed [qte_pkg::AYW-1:0] angle_about_y,
    output logic signed [qte_pkg::AXW-1:0] angle_about_z
);
    import qte_pkg::*;

    localparam int VL = SQ_STAGES + CORDIC_STAGES + 3;
    localparam int QBW = ZW - 9;

    logic en;
    logic vld_reg [0:VL-1];
    logic out_valid_reg;
    qte_item_t sat_item;
    qte_item_t b0_reg;
    qte_item_t dl_reg [0:SQ_STAGES];
    logic [RW-1:0] root;
    logic signed [ZW-1:0] z1, z2, z3;
    logic signed [AXW-1:0] ax_reg, az_reg;
    logic signed [AYW-1:0] ay_reg;

    function automatic logic signed [QBW-1:0] to_out(input logic signed [ZW-1:0] z,
                                                     input int lim);
        logic signed [ZW-1:0] r;
        logic signed [QBW-1:0] q;
        r = (z + ZW'(256)) >>> 9;
        q = r[QBW-1:0];
        if (q > QBW'(lim))
            q = QBW'(lim);
        else if (q < -QBW'(lim))
            q = -QBW'(lim);
        return q;
    endfunction

    assign en = !out_valid_reg || !angle_stall;
    assign pop = en && not_empty;
    assign angle_valid = out_valid_reg;
    assign angle_about_x = ax_reg;
    assign angle_about_y = ay_reg;
    assign angle_about_z = az_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VL; k++)
                vld_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= not_empty;
            for (int k = 1; k < VL; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_valid_reg <= vld_reg[VL-1];
        end
    end

    // saturate asin argument to +-1.0
    always_comb
    begin
        sat_item = head_item;
        if (head_item.sr > PW'(S_LIMIT))
            sat_item.sr = PW'(S_LIMIT);
        else if (head_item.sr < -PW'(S_LIMIT))
            sat_item.sr = -PW'(S_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg <= sat_item;
            dl_reg[0] <= b0_reg;
            for (int k = 1; k <= SQ_STAGES; k++)
                dl_reg[k] <= dl_reg[k-1];
            ax_reg <= AXW'(to_out(z1, ATAN_LIMIT));
            ay_reg <= AYW'(to_out(z2, ASIN_LIMIT));
            az_reg <= AXW'(to_out(z3, ATAN_LIMIT));
        end
    end

    qte_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .s    (b0_reg.sr[SW-1:0]),
        .root (root)
    );

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_x (
        .clk   (clk),
        .en    (en),
        .vy    (dl_reg[SQ_STAGES].a1y),
        .vx    (dl_reg[SQ_STAGES].a1x),
        .angle (z1)
    );

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_y (
        .clk   (clk),
        .en    (en),
        .vy    (dl_reg[SQ_STAGES].sr),
        .vx    ($signed(PW'(root))),
        .angle (z2)
    );

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_z (
        .clk   (clk),
        .en    (en),
        .vy    (dl_reg[SQ_STAGES].a3y),
        .vx    (dl_reg[SQ_STAGES].a3x),
        .angle (z3)
    );

endmodule

FILE: sv/quaternion_to_euler_angles.sv
// Quaternion to Euler angles. Takes one Q14 quaternion (w, x, y, z) per
// request and returns roll, pitch and yaw in 1/128 degree: two atan2 angles
// clamped to +-180 degrees and an asin angle whose argument saturates at
// +-1, so it clamps at +-90 degrees. One request is accepted every cycle
// while the output side keeps up. An accepted request passes through the
// front registers, the queue and the back stages (saturate, square, 29
// root stages, pre-rotation, CORDIC stages, output rounding); the 29-stage
// square root for the asin cosine term is the longest of these. A stalled
// output freezes the back pipeline; the 4-entry queue then fills and the
// input stalls.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = qte_pkg::QTE_CORDIC_STAGES   // 8 to 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           quat_valid,
    output logic                           quat_stall,
    input  logic signed [qte_pkg::QW-1:0]  quat_w,
    input  logic signed [qte_pkg::QW-1:0]  quat_x,
    input  logic signed [qte_pkg::QW-1:0]  quat_y,
    input  logic signed [qte_pkg::QW-1:0]  quat_z,
    output logic                           angle_valid,
    input  logic                           angle_stall,
    output logic signed [qte_pkg::AXW-1:0] angle_about_x,
    output logic signed [qte_pkg::AYW-1:0] angle_about_y,
    output logic signed [qte_pkg::AXW-1:0] angle_about_z
);
    import qte_pkg::*;

    // front -> queue
    logic push;
    qte_item_t push_item;
    logic queue_full;

    // queue -> back
    logic pop;
    qte_item_t head_item;
    logic not_empty;

    // Front: registers the request, forms the ten products, then the
    // sums, some of them doubled, that feed atan2 and asin.
    qte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .quat_valid (quat_valid),
        .quat_stall (quat_stall),
        .quat_w     (quat_w),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Short queue decoupling the two halves.
    qte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (not_empty),
        .full      (queue_full)
    );

    // Back: square root for the asin cosine, three CORDIC lanes, rounding.
    qte_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_item     (head_item),
        .not_empty     (not_empty),
        .pop           (pop),
        .angle_valid   (angle_valid),
        .angle_stall   (angle_stall),
        .angle_about_x (angle_about_x),
        .angle_about_y (angle_about_y),
        .angle_about_z (angle_about_z)
    );

endmodule

FILE: dv/quaternion_to_euler_angles_tb.sv
`timescale 1ns / 100ps

// Streams quaternions into the Euler angle block and checks every returned
// angle triple against an in-bench fixed-point predictor of the atan2/asin
// CORDIC datapath. Both handshake sides idle at random.
module quaternion_to_euler_angles_tb;
    import qte_pkg::*;

    localparam int STAGES = QTE_CORDIC_STAGES;
    localparam int LATENCY = STAGES + 40;
    localparam int RANDOM_QUATS = 700;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } quat_t;

    typedef struct {
        logic signed [AXW-1:0] roll;
        logic signed [AYW-1:0] pitch;
        logic signed [AXW-1:0] yaw;
    } euler_t;

    logic clk;
    logic rst_n;
    logic quat_valid;
    logic quat_stall;
    logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
    logic angle_valid;
    logic angle_stall;
    logic signed [AXW-1:0] angle_about_x;
    logic signed [AYW-1:0] angle_about_y;
    logic signed [AXW-1:0] angle_about_z;

    quat_t  pending_quats[$];
    euler_t expected_angles[$];
    int     error_count;
    longint cycle_count;
    bit     calm_stretch;   // no idling on either side while set

    quaternion_to_euler_angles i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .quat_valid    (quat_valid),
        .quat_stall    (quat_stall),
        .quat_w        (quat_w),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z),
        .angle_valid   (angle_valid),
        .angle_stall   (angle_stall),
        .angle_about_x (angle_about_x),
        .angle_about_y (angle_about_y),
        .angle_about_z (angle_about_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // floor division by 2^s; >>> on signed longint already floors
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // vectoring CORDIC, angle in 1/65536 degree
    function automatic longint cordic_angle(longint vy, longint vx);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (vx == 0 && vy == 0)
            return 0;
        // left half plane: pre-rotate by 90 degrees toward the right
        if (vx < 0)
        begin
            t = vx;
            if (vy >= 0)
            begin
                vx = vy;
                vy = -t;
                acc = 90 * longint'(DEG_UNIT);
            end
            else
            begin
                vx = -vy;
                vy = t;
                acc = -90 * longint'(DEG_UNIT);
            end
        end
        for (int i = 0; i < STAGES && i < ATAN_TABLE_LEN; i++)
        begin
            dx = floor_shift(vy, i);
            dy = floor_shift(vx, i);
            if (vy >= 0)
            begin
                vx += dx;
                vy -= dy;
                acc += longint'(atan_entry(i));
            end
            else
            begin
                vx -= dx;
                vy += dy;
                acc -= longint'(atan_entry(i));
            end
        end
        return acc;
    endfunction

    function automatic longint deg128(longint a, longint lim);
        return clamp_sym(floor_shift(a + 256, 9), lim);
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic euler_t predict_angles(quat_t q);
        longint w, x, y, z, s, c;
        euler_t e;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        e.roll = AXW'(deg128(cordic_angle(2 * (y * z + w * x),
                                          w * w - x * x - y * y + z * z), ATAN_LIMIT));
        s = clamp_sym(2 * (w * y - x * z), S_LIMIT);
        c = root_floor((64'd1 << 56) - longint'(s * s));
        e.pitch = AYW'(deg128(cordic_angle(s, c), ASIN_LIMIT));
        e.yaw = AXW'(deg128(cordic_angle(2 * (x * y + w * z),
                                         w * w + x * x - y * y - z * z), ATAN_LIMIT));
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    function automatic quat_t make_quat(int w, int x, int y, int z);
        quat_t q;
        q.w = QW'(w);
        q.x = QW'(x);
        q.y = QW'(y);
        q.z = QW'(z);
        return q;
    endfunction

    function automatic logic signed [QW-1:0] rand_component();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return QW'($urandom_range(0, 32768) - 16384);
        if (pick < 80)
            return QW'($urandom);          // any bit pattern
        if (pick < 90)
            return QW'($urandom_range(0, 64) - 32);
        return ($urandom_range(0, 1)) ? QW'(16384) : QW'(-16384);
    endfunction

    // roughly unit quaternion with random direction
    function automatic quat_t rand_unit_quat();
        real a, b, c, d, n;
        a = $urandom_range(0, 20000) - 10000.0;
        b = $urandom_range(0, 20000) - 10000.0;
        c = $urandom_range(0, 20000) - 10000.0;
        d = $urandom_range(0, 20000) - 10000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            return make_quat(16384, 0, 0, 0);
        return make_quat($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                         $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0));
    endfunction

    initial
    begin
        quat_t q;
        int r;
        // directed: identity, axes, gimbal lock, zero vectors, extremes
        pending_quats.push_back(make_quat(16384, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 16384, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 16384, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 16384));
        pending_quats.push_back(make_quat(-16384, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 0));
        pending_quats.push_back(make_quat(11585, 0, 11585, 0));    // pitch +90
        pending_quats.push_back(make_quat(11585, 0, -11585, 0));   // pitch -90
        pending_quats.push_back(make_quat(16384, 0, 16384, 0));    // asin saturates high
        pending_quats.push_back(make_quat(16384, 0, -16384, 0));   // asin saturates low
        pending_quats.push_back(make_quat(8192, 8192, 8192, 8192));
        pending_quats.push_back(make_quat(-8192, 8192, -8192, 8192));
        pending_quats.push_back(make_quat(11585, 11585, 0, 0));    // roll 90
        pending_quats.push_back(make_quat(0, 11585, 0, 11585));
        pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
        pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
        pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
        pending_quats.push_back(make_quat(1, -1, 0, 0));
        pending_quats.push_back(make_quat(0, 1, 1, 0));
        pending_quats.push_back(make_quat(-16384, 16384, -16384, 16384));
        pending_quats.push_back(make_quat(-1, 0, 0, 0));
        for (int i = 0; i < RANDOM_QUATS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                q = rand_unit_quat();
            else
                q = make_quat(rand_component(), rand_component(),
                              rand_component(), rand_component());
            pending_quats.push_back(q);
        end
    end

    // ---------------------------------------------------------------
    // Reset, idling control, cycle limit
    // ---------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        // a stretch with no idling
        calm_stretch <= (cycle_count > 250 && cycle_count < 550);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Driver: changes inputs at the falling edge
    // ---------------------------------------------------------------

    bit accepted_last;  // request taken at the previous rising edge

    always @(posedge clk)
        accepted_last <= rst_n && quat_valid && !quat_stall;

    always @(negedge clk)
    begin
        quat_t q;
        if (rst_n)
        begin
            angle_stall <= !calm_stretch && ($urandom_range(0, 99) < 14);
            // a held request stays put until taken
            if (!quat_valid || accepted_last)
            begin
                if (pending_quats.size() != 0 &&
                    (calm_stretch || $urandom_range(0, 99) >= 14))
                begin
                    q = pending_quats.pop_front();
                    quat_w <= q.w;
                    quat_x <= q.x;
                    quat_y <= q.y;
                    quat_z <= q.z;
                    quat_valid <= 1'b1;
                end
                else
                    quat_valid <= 1'b0;
            end
        end
        else
        begin
            quat_valid <= 1'b0;
            quat_w <= '0;
            quat_x <= '0;
            quat_y <= '0;
            quat_z <= '0;
            angle_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predicts on input acceptance, checks on output acceptance
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s at cycle %0d: got %0d expected %0d",
                 what, cycle_count, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        euler_t want;
        if (rst_n)
        begin
            if (quat_valid && !quat_stall)
                expected_angles.push_back(predict_angles(make_quat(quat_w, quat_x,
                                                                   quat_y, quat_z)));
            if (angle_valid && !angle_stall)
            begin
                if (expected_angles.size() == 0)
                    report_mismatch("unexpected result", angle_about_x, 0);
                else
                begin
                    want = expected_angles.pop_front();
                    if (angle_about_x !== want.roll)
                        report_mismatch("angle_about_x", angle_about_x, want.roll);
                    if (angle_about_y !== want.pitch)
                        report_mismatch("angle_about_y", angle_about_y, want.pitch);
                    if (angle_about_z !== want.yaw)
                        report_mismatch("angle_about_z", angle_about_z, want.yaw);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // End of run
    // ---------------------------------------------------------------

    initial
    begin
        @(posedge rst_n);
        wait (pending_quats.size() == 0);
        @(posedge clk);
        while (quat_valid)
            @(posedge clk);
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (error_count == 0 && expected_angles.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
